// File: design/roi_avg_pkg.sv
// Shared types, codes and helpers of the region-of-interest color averager.
// No dependencies; every module of the block imports this package.
package roi_avg_pkg;

    localparam int IN_W       = 16;   // width of a sample port
    localparam int AVG_W      = 24;   // Q16.8 average
    localparam int FRAC_BITS  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CORNER_W   = 16;
    localparam int DIM_REG_W  = 11;
    localparam int NUM_CH     = 4;
    localparam int QDEPTH     = 4;    // front-to-back queue entries

    localparam logic [AVG_W-1:0] ONE_Q8 = AVG_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_A_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_A_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_B_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_B_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FMT   = 3'd6;

    typedef enum logic [1:0] {
        FMT_L    = 2'd0,
        FMT_LA   = 2'd1,
        FMT_RGB  = 2'd2,
        FMT_RGBA = 2'd3
    } fmt_t;

    // coordinates wide enough for a signed corner and a zero-extended dimension
    typedef logic signed [CORNER_W:0] coord_t;

    // per-pixel control carried from the front to the back
    typedef struct packed {
        logic last;    // pixel closes the frame
        logic empty;   // clamped rectangle holds no pixel
        fmt_t fmt;
    } px_ctrl_t;

    function automatic coord_t span_lo(logic signed [CORNER_W-1:0] a,
                                       logic signed [CORNER_W-1:0] b);
        coord_t mn;
        mn = (a < b) ? coord_t'(a) : coord_t'(b);
        return (mn < 0) ? coord_t'(0) : mn;
    endfunction

    function automatic coord_t span_hi(logic signed [CORNER_W-1:0] a,
                                       logic signed [CORNER_W-1:0] b,
                                       coord_t dim);
        coord_t mx;
        mx = (a < b) ? coord_t'(b) : coord_t'(a);
        return (mx > dim) ? dim : mx;
    endfunction

endpackage

// File: design/roi_avg_queue.sv
// Small register queue between the pixel front and the accumulating back.
// Depends on roi_avg_pkg for the depth.
module roi_avg_queue
    import roi_avg_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             not_empty
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/roi_avg_front.sv
// Front of the averager: configuration registers, raster counters, and the
// per-pixel rectangle test. Depends on roi_avg_pkg.
module roi_avg_front
    import roi_avg_pkg::*;
#(
    parameter int MAX_DIM     = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int DIM_W       = $clog2(MAX_DIM + 1),
    parameter int CNT_W       = 2 * DIM_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  px_take,
    input  logic [IN_W-1:0]       sample_ch0,
    input  logic [IN_W-1:0]       sample_ch1,
    input  logic [IN_W-1:0]       sample_ch2,
    input  logic [IN_W-1:0]       sample_ch3,
    output px_ctrl_t              px_ctrl,
    output logic [CNT_W-1:0]      px_count,
    output logic [NUM_CH-1:0][SAMPLE_BITS-1:0] px_samples
);

    localparam int POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic signed [CORNER_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [DIM_REG_W-1:0]       fw_reg, fh_reg;
    fmt_t                       fmt_reg;
    logic [POS_W-1:0]           col_reg, col_next;
    logic [POS_W-1:0]           row_reg, row_next;

    logic [DIM_W-1:0] w_eff, h_eff;
    coord_t           xlo, xhi, ylo, yhi, col_s, row_s;
    logic             in_rect, col_wrap, row_wrap, rect_empty;
    logic [DIM_W-1:0] x_span, y_span;
    logic [NUM_CH-1:0][SAMPLE_BITS-1:0] raw;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (fw_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(fw_reg) > MAX_DIM)
            w_eff = DIM_W'(MAX_DIM);
        else
            w_eff = DIM_W'(fw_reg);
        if (fh_reg == '0)
            h_eff = DIM_W'(1);
        else if (32'(fh_reg) > MAX_DIM)
            h_eff = DIM_W'(MAX_DIM);
        else
            h_eff = DIM_W'(fh_reg);
    end

    always_comb
    begin
        xlo   = span_lo(ax_reg, bx_reg);
        xhi   = span_hi(ax_reg, bx_reg, coord_t'(w_eff));
        ylo   = span_lo(ay_reg, by_reg);
        yhi   = span_hi(ay_reg, by_reg, coord_t'(h_eff));
        col_s = coord_t'(col_reg);
        row_s = coord_t'(row_reg);

        in_rect    = (col_s >= xlo) && (col_s < xhi) && (row_s >= ylo) && (row_s < yhi);
        rect_empty = !((xhi > xlo) && (yhi > ylo));
        x_span     = DIM_W'(xhi - xlo);
        y_span     = DIM_W'(yhi - ylo);

        // row ends once col+1 reaches the width, also when the width shrank
        col_wrap = !((DIM_W + 1)'(col_reg) + 1'b1 < (DIM_W + 1)'(w_eff));
        row_wrap = !((DIM_W + 1)'(row_reg) + 1'b1 < (DIM_W + 1)'(h_eff));
        col_next = col_wrap ? '0 : col_reg + 1'b1;
        row_next = col_wrap ? (row_wrap ? '0 : row_reg + 1'b1) : row_reg;
    end

    assign raw[0] = sample_ch0[SAMPLE_BITS-1:0];
    assign raw[1] = sample_ch1[SAMPLE_BITS-1:0];
    assign raw[2] = sample_ch2[SAMPLE_BITS-1:0];
    assign raw[3] = sample_ch3[SAMPLE_BITS-1:0];

    // zero what must not be summed: pixel outside, or channel beyond the format
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            px_samples[c] = (in_rect && (c <= int'(fmt_reg))) ? raw[c] : '0;
        end
        px_ctrl.last  = col_wrap && row_wrap;
        px_ctrl.empty = rect_empty;
        px_ctrl.fmt   = fmt_reg;
        px_count      = rect_empty ? '0 : CNT_W'(x_span) * CNT_W'(y_span);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg  <= '0;
            ay_reg  <= '0;
            bx_reg  <= '0;
            by_reg  <= '0;
            fw_reg  <= DIM_REG_W'(1024);
            fh_reg  <= DIM_REG_W'(1024);
            fmt_reg <= FMT_RGBA;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CORNER_A_X: ax_reg  <= cfg_data;
                CFG_CORNER_A_Y: ay_reg  <= cfg_data;
                CFG_CORNER_B_X: bx_reg  <= cfg_data;
                CFG_CORNER_B_Y: by_reg  <= cfg_data;
                CFG_FRAME_W:    fw_reg  <= cfg_data[DIM_REG_W-1:0];
                CFG_FRAME_H:    fh_reg  <= cfg_data[DIM_REG_W-1:0];
                CFG_PIXEL_FMT:  fmt_reg <= fmt_t'(cfg_data[1:0]);
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (px_take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: design/roi_avg_accum.sv
// Back half, first part: pops classified pixels and adds them into the
// four channel sums; hands the sums over at frame end. Depends on roi_avg_pkg.
module roi_avg_accum
    import roi_avg_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 38
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  px_ctrl_t                            q_ctrl,
    input  logic [NUM_CH-1:0][SAMPLE_BITS-1:0]  q_samples,
    output logic                                q_pop,
    input  logic                                div_ready,
    output logic                                div_start,
    output logic [NUM_CH-1:0][SUM_W-1:0]        frame_sums
);

    logic [NUM_CH-1:0][SUM_W-1:0] sums_reg, sums_next;

    // a frame-closing pixel waits until the divider is free
    assign q_pop     = q_valid && (!q_ctrl.last || div_ready);
    assign div_start = q_pop && q_ctrl.last;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            frame_sums[c] = sums_reg[c] + SUM_W'(q_samples[c]);
        end
        sums_next = sums_reg;
        if (q_pop)
        begin
            sums_next = q_ctrl.last ? '0 : frame_sums;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sums_reg <= '0;
        else
            sums_reg <= sums_next;
    end

endmodule

// File: design/roi_avg_div.sv
// Back half, second part: restoring divider run on four lanes at once,
// format swizzle and the result register. Depends on roi_avg_pkg.
module roi_avg_div
    import roi_avg_pkg::*;
#(
    parameter int SUM_W = 38,
    parameter int CNT_W = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_CH-1:0][SUM_W-1:0]  sums,
    input  logic [CNT_W-1:0]              count,
    input  px_ctrl_t                      ctrl,
    output logic                          ready,
    input  logic                          pop,
    output logic                          res_valid,
    output logic [AVG_W-1:0]              avg_red,
    output logic [AVG_W-1:0]              avg_green,
    output logic [AVG_W-1:0]              avg_blue,
    output logic [AVG_W-1:0]              avg_alpha,
    output logic                          region_empty
);

    localparam int DIVD_W = SUM_W + FRAC_BITS;
    localparam int STEP_W = $clog2(DIVD_W + 1);

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_DONE = 3'b100
    } div_state_t;

    div_state_t                    state_reg, state_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [NUM_CH-1:0][DIVD_W-1:0] dvd_reg, dvd_next;
    logic [NUM_CH-1:0][CNT_W-1:0]  rem_reg, rem_next;
    logic [NUM_CH-1:0][AVG_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]              dsr_reg, dsr_next;
    px_ctrl_t                      ctrl_reg, ctrl_next;

    logic                          out_valid_reg, out_valid_next;
    logic [NUM_CH-1:0][AVG_W-1:0]  out_reg, out_next;
    logic                          out_empty_reg, out_empty_next;

    logic [CNT_W:0]                trial [NUM_CH];
    logic                          load_out;
    logic [NUM_CH-1:0][AVG_W-1:0]  swz;

    assign ready = (state_reg == DIV_IDLE);
    assign load_out = (state_reg == DIV_DONE) && (!out_valid_reg || pop);

    // swizzle by format; an empty region gives zeros with no swizzle
    always_comb
    begin
        swz = quo_reg;
        if (ctrl_reg.empty)
        begin
            swz = '0;
        end
        else
        begin
            unique case (ctrl_reg.fmt)
                FMT_L:
                begin
                    swz[1] = quo_reg[0];
                    swz[2] = quo_reg[0];
                    swz[3] = ONE_Q8;
                end
                FMT_LA:
                begin
                    swz[1] = quo_reg[0];
                    swz[2] = quo_reg[0];
                    swz[3] = quo_reg[1];
                end
                FMT_RGB:  swz[3] = ONE_Q8;
                FMT_RGBA: ;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        ctrl_next  = ctrl_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            trial[c] = {rem_reg[c], dvd_reg[c][DIVD_W-1]};
        end

        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        dvd_next[c] = {sums[c], FRAC_BITS'(0)};
                    end
                    rem_next   = '0;
                    quo_next   = '0;
                    dsr_next   = count;
                    ctrl_next  = ctrl;
                    step_next  = STEP_W'(DIVD_W);
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                // one quotient bit per lane per cycle; high bits fall off the top
                for (int c = 0; c < NUM_CH; c++)
                begin
                    dvd_next[c] = {dvd_reg[c][DIVD_W-2:0], 1'b0};
                    if (trial[c] >= {1'b0, dsr_reg})
                    begin
                        rem_next[c] = CNT_W'(trial[c] - {1'b0, dsr_reg});
                        quo_next[c] = {quo_reg[c][AVG_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[c] = CNT_W'(trial[c]);
                        quo_next[c] = {quo_reg[c][AVG_W-2:0], 1'b0};
                    end
                end
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                if (load_out)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_empty_next = out_empty_reg;
        priority if (load_out)
        begin
            out_next       = swz;
            out_empty_next = ctrl_reg.empty;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dsr_reg       <= dsr_next;
        ctrl_reg      <= ctrl_next;
        out_reg       <= out_next;
        out_empty_reg <= out_empty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= DIV_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid    = out_valid_reg;
    assign avg_red      = out_reg[0];
    assign avg_green    = out_reg[1];
    assign avg_blue     = out_reg[2];
    assign avg_alpha    = out_reg[3];
    assign region_empty = out_empty_reg;

endmodule

// File: design/roi_rectangle_color_average_unit.sv
// Top level of the region-of-interest color averager: front, queue,
// accumulator and divider. Depends on roi_avg_pkg and the roi_avg_* modules.
//
//   channel   | handshake           | payload
//   ----------+---------------------+----------------------------------------
//   pixel in  | push / full         | sample_ch0 .. sample_ch3
//   result    | pop / empty         | avg_red, avg_green, avg_blue, avg_alpha,
//             |                     | region_empty
//   config    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pixel per cycle while full is low; a pixel goes into the queue, then into
// the sums when the accumulator pops it. A frame end runs a bit-serial divide
// of the four sums by the pixel count; the next frame end is taken only once the
// divider has loaded its result register and is idle again. full rises only
// when a frame ends while the divider is busy or holds an unpopped result;
// cfg_ready is always high. rst_n resets control, sums and settings; no clearing pass.
module roi_rectangle_color_average_unit
    import roi_avg_pkg::*;
#(
    parameter int MAX_DIM     = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [IN_W-1:0]       sample_ch0,
    input  logic [IN_W-1:0]       sample_ch1,
    input  logic [IN_W-1:0]       sample_ch2,
    input  logic [IN_W-1:0]       sample_ch3,
    output logic                  empty,
    input  logic                  pop,
    output logic [AVG_W-1:0]      avg_red,
    output logic [AVG_W-1:0]      avg_green,
    output logic [AVG_W-1:0]      avg_blue,
    output logic [AVG_W-1:0]      avg_alpha,
    output logic                  region_empty,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W  = 2 * DIM_W;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int SMP_W  = NUM_CH * SAMPLE_BITS;
    localparam int ITEM_W = $bits(px_ctrl_t) + CNT_W + SMP_W;

    logic                               px_take;
    px_ctrl_t                           f_ctrl, q_ctrl;
    logic [CNT_W-1:0]                   f_count, q_count;
    logic [NUM_CH-1:0][SAMPLE_BITS-1:0] f_samples, q_samples;
    logic [ITEM_W-1:0]                  q_rd_data;
    logic                               q_valid, q_pop;
    logic                               div_ready, div_start, res_valid;
    logic [NUM_CH-1:0][SUM_W-1:0]       frame_sums;

    assign px_take = push && !full;

    roi_avg_front #(
        .MAX_DIM     (MAX_DIM),
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIM_W       (DIM_W),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .px_take    (px_take),
        .sample_ch0 (sample_ch0),
        .sample_ch1 (sample_ch1),
        .sample_ch2 (sample_ch2),
        .sample_ch3 (sample_ch3),
        .px_ctrl    (f_ctrl),
        .px_count   (f_count),
        .px_samples (f_samples)
    );

    roi_avg_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (px_take),
        .wr_data   ({f_ctrl, f_count, f_samples}),
        .rd_en     (q_pop),
        .rd_data   (q_rd_data),
        .full      (full),
        .not_empty (q_valid)
    );

    assign {q_ctrl, q_count, q_samples} = q_rd_data;

    roi_avg_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ctrl     (q_ctrl),
        .q_samples  (q_samples),
        .q_pop      (q_pop),
        .div_ready  (div_ready),
        .div_start  (div_start),
        .frame_sums (frame_sums)
    );

    roi_avg_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .sums         (frame_sums),
        .count        (q_count),
        .ctrl         (q_ctrl),
        .ready        (div_ready),
        .pop          (pop),
        .res_valid    (res_valid),
        .avg_red      (avg_red),
        .avg_green    (avg_green),
        .avg_blue     (avg_blue),
        .avg_alpha    (avg_alpha),
        .region_empty (region_empty)
    );

    assign empty = !res_valid;

endmodule

// File: design/roi_avg_checker.sv
// Port-level checks of the region-of-interest color averager, bound to the
// top level. Depends on roi_avg_pkg and roi_rectangle_color_average_unit.
module roi_avg_port_checker
    import roi_avg_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input logic             cfg_ready,
    input logic [AVG_W-1:0] avg_red,
    input logic [AVG_W-1:0] avg_green,
    input logic [AVG_W-1:0] avg_blue,
    input logic [AVG_W-1:0] avg_alpha,
    input logic             region_empty
);

    // nothing queued and no result right after a reset cycle
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queue or result not clear after reset");

    // empty region reports all-zero averages, alpha included
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && region_empty |->
            avg_red == '0 && avg_green == '0 && avg_blue == '0 && avg_alpha == '0)
        else $error("empty region with nonzero average");

    // a result not taken stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(avg_red) && $stable(avg_green)
            && $stable(avg_blue) && $stable(avg_alpha) && $stable(region_empty))
        else $error("waiting result changed");

    // register writes never back-pressure
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind roi_rectangle_color_average_unit roi_avg_port_checker u_roi_avg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .cfg_ready    (cfg_ready),
    .avg_red      (avg_red),
    .avg_green    (avg_green),
    .avg_blue     (avg_blue),
    .avg_alpha    (avg_alpha),
    .region_empty (region_empty)
);

// File: test/roi_avg_checker.sv
// Checker for the region-of-interest color averager: follows register writes and
// pixel requests, predicts each frame's averages and compares popped results.
// Depends on roi_avg_pkg only.
module roi_avg_checker
    import roi_avg_pkg::*;
#(
    parameter int MAX_DIM     = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [IN_W-1:0]       sample_ch0,
    input  logic [IN_W-1:0]       sample_ch1,
    input  logic [IN_W-1:0]       sample_ch2,
    input  logic [IN_W-1:0]       sample_ch3,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [AVG_W-1:0]      avg_red,
    input  logic [AVG_W-1:0]      avg_green,
    input  logic [AVG_W-1:0]      avg_blue,
    input  logic [AVG_W-1:0]      avg_alpha,
    input  logic                  region_empty,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    awaiting
);

    typedef struct packed {
        logic [AVG_W-1:0] red;
        logic [AVG_W-1:0] green;
        logic [AVG_W-1:0] blue;
        logic [AVG_W-1:0] alpha;
        logic             none;
    } frame_avg_t;

    logic signed [CORNER_W-1:0] corner_ax, corner_ay, corner_bx, corner_by;
    logic [DIM_REG_W-1:0]       width_reg, height_reg;
    fmt_t                       fmt_reg;
    logic [63:0]                channel_total [NUM_CH];
    int                         col_pos, row_pos;
    frame_avg_t                 frame_averages [$];
    frame_avg_t                 popped;

    function automatic int usable_dim(input logic [DIM_REG_W-1:0] d);
        if (d == '0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    task automatic take_pixel(input logic [NUM_CH*IN_W-1:0] px);
        int          w, h, x_lo, x_hi, y_lo, y_hi, a, b, nch, c;
        logic [63:0] area, smask;
        logic [63:0] avg [NUM_CH];
        frame_avg_t  res;
        w = usable_dim(width_reg);
        h = usable_dim(height_reg);
        a = corner_ax;
        b = corner_bx;
        x_lo = (a < b) ? a : b;
        x_hi = (a < b) ? b : a;
        if (x_lo < 0) x_lo = 0;
        if (x_hi > w) x_hi = w;
        a = corner_ay;
        b = corner_by;
        y_lo = (a < b) ? a : b;
        y_hi = (a < b) ? b : a;
        if (y_lo < 0) y_lo = 0;
        if (y_hi > h) y_hi = h;
        nch = int'(fmt_reg) + 1;
        smask = (64'd1 << SAMPLE_BITS) - 64'd1;

        if (col_pos >= x_lo && col_pos < x_hi && row_pos >= y_lo && row_pos < y_hi)
            for (c = 0; c < nch; c++)
                channel_total[c] += 64'(px[c*IN_W +: IN_W]) & smask;

        if (col_pos < w - 1) begin
            col_pos++;
        end else begin
            col_pos = 0;
            if (row_pos < h - 1) begin
                row_pos++;
            end else begin
                // frame done: divide, swizzle, restart the sums
                row_pos = 0;
                res.none = !(x_hi > x_lo && y_hi > y_lo);
                for (c = 0; c < NUM_CH; c++)
                    avg[c] = '0;
                if (!res.none) begin
                    area = 64'(x_hi - x_lo) * 64'(y_hi - y_lo);
                    for (c = 0; c < NUM_CH; c++)
                        avg[c] = (channel_total[c] << FRAC_BITS) / area;
                end
                res.red   = avg[0][AVG_W-1:0];
                res.green = avg[1][AVG_W-1:0];
                res.blue  = avg[2][AVG_W-1:0];
                res.alpha = avg[3][AVG_W-1:0];
                if (!res.none)
                    case (fmt_reg)
                        FMT_L:
                        begin
                            res.green = res.red;
                            res.blue  = res.red;
                            res.alpha = ONE_Q8;
                        end
                        FMT_LA:
                        begin
                            res.alpha = avg[1][AVG_W-1:0];
                            res.green = res.red;
                            res.blue  = res.red;
                        end
                        FMT_RGB: res.alpha = ONE_Q8;
                        default: ;
                    endcase
                frame_averages.push_back(res);
                for (c = 0; c < NUM_CH; c++)
                    channel_total[c] = '0;
            end
        end
    endtask

    task automatic check_field(input string what, input logic [AVG_W-1:0] want,
                               input logic [AVG_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_ax  = '0;
            corner_ay  = '0;
            corner_bx  = '0;
            corner_by  = '0;
            width_reg  = DIM_REG_W'(1024);
            height_reg = DIM_REG_W'(1024);
            fmt_reg    = FMT_RGBA;
            for (int c = 0; c < NUM_CH; c++)
                channel_total[c] = '0;
            col_pos = 0;
            row_pos = 0;
            frame_averages.delete();
            errors   = 0;
            awaiting = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (frame_averages.size() == 0)
                begin
                    errors++;
                    $display("%0t: result request with nothing expected: expected none, actual red %0d",
                             $time, avg_red);
                end
                else
                begin
                    popped = frame_averages.pop_front();
                    check_field("avg_red", popped.red, avg_red);
                    check_field("avg_green", popped.green, avg_green);
                    check_field("avg_blue", popped.blue, avg_blue);
                    check_field("avg_alpha", popped.alpha, avg_alpha);
                    check_field("region_empty", AVG_W'(popped.none), AVG_W'(region_empty));
                end
            end

            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_CORNER_A_X: corner_ax  = cfg_data[CORNER_W-1:0];
                    CFG_CORNER_A_Y: corner_ay  = cfg_data[CORNER_W-1:0];
                    CFG_CORNER_B_X: corner_bx  = cfg_data[CORNER_W-1:0];
                    CFG_CORNER_B_Y: corner_by  = cfg_data[CORNER_W-1:0];
                    CFG_FRAME_W:    width_reg  = cfg_data[DIM_REG_W-1:0];
                    CFG_FRAME_H:    height_reg = cfg_data[DIM_REG_W-1:0];
                    CFG_PIXEL_FMT:  fmt_reg    = fmt_t'(cfg_data[1:0]);
                    default: ;
                endcase

            if (push && !full)
                take_pixel({sample_ch3, sample_ch2, sample_ch1, sample_ch0});

            awaiting = frame_averages.size();
        end
    end

endmodule

// File: test/roi_rectangle_color_average_unit_tb.sv
// Testbench top for roi_rectangle_color_average_unit: drives register writes,
// and pixel requests and result pops with random gaps; roi_avg_checker judges.
// Depends on roi_avg_pkg, the block and roi_avg_checker.
module roi_rectangle_color_average_unit_tb;
    import roi_avg_pkg::*;

    localparam int                   MAX_DIM       = 1024;
    localparam int                   PIXEL_TARGET  = 1700;
    localparam int                   SETTLE_CYCLES = 64;
    localparam int                   HOLD_CYCLES   = 200;
    localparam int                   GAP_PCT       = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [IN_W-1:0]       sample_ch0, sample_ch1, sample_ch2, sample_ch3;
    logic                  empty;
    logic                  pop;
    logic [AVG_W-1:0]      avg_red, avg_green, avg_blue, avg_alpha;
    logic                  region_empty;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int expected_left;
    int frame_pixels;
    int hold_count  = 0;
    bit hold_served = 1'b0;
    bit hold_wanted;
    bit calm;

    roi_rectangle_color_average_unit uut (.*);

    roi_avg_checker avg_check (
        .*,
        .errors   (fail_count),
        .awaiting (expected_left)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int used_dim(input logic [DIM_REG_W-1:0] d);
        if (d == '0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    // mostly near the frame, sometimes anywhere in the 16-bit range
    function automatic logic [CORNER_W-1:0] pick_corner(input int dim);
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom_range(dim + 4) - 2);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // wait for the block to go idle, then load a whole frame setup
    task automatic set_frame(input logic [CORNER_W-1:0] ax, ay, bx, by,
                             input logic [DIM_REG_W-1:0] w, h, input fmt_t f);
        @(negedge clk);
        push <= 1'b0;
        while (expected_left != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(CFG_CORNER_A_X, ax);
        write_reg(CFG_CORNER_A_Y, ay);
        write_reg(CFG_CORNER_B_X, bx);
        write_reg(CFG_CORNER_B_Y, by);
        write_reg(CFG_FRAME_W, {5'($urandom), w});
        write_reg(CFG_FRAME_H, {5'($urandom), h});
        write_reg(CFG_PIXEL_FMT, {14'($urandom), f});
        if ($urandom_range(3) == 0)
            write_reg(CFG_UNUSED, 16'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
        frame_pixels = used_dim(w) * used_dim(h);
    endtask

    task automatic send_pixel(input logic [IN_W-1:0] s0, s1, s2, s3);
        while (!calm && $urandom_range(99) < GAP_PCT)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push       <= 1'b1;
        sample_ch0 <= s0;
        sample_ch1 <= s1;
        sample_ch2 <= s2;
        sample_ch3 <= s3;
        do @(posedge clk); while (full);
    endtask

    task automatic send_random_pixels(input int n);
        repeat (n)
            send_pixel(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // result side: random pops, one long hold-off when asked
    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_wanted && !hold_served)
            begin
                pop <= 1'b0;
                hold_count++;
                if (hold_count == HOLD_CYCLES)
                    hold_served = 1'b1;
            end
            else
            begin
                pop <= calm || ($urandom_range(99) >= GAP_PCT);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("roi_rectangle_color_average_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        logic [DIM_REG_W-1:0] w, h;
        int                   frame_idx, pixels_sent;

        rst_n       = 1'b0;
        push        = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        sample_ch0  = '0;
        sample_ch1  = '0;
        sample_ch2  = '0;
        sample_ch3  = '0;
        calm        = 1'b0;
        hold_wanted = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full-scale samples, RGBA
        set_frame(0, 0, 2, 2, 11'd2, 11'd2, FMT_RGBA);
        repeat (4) send_pixel('1, '1, '1, '1);
        // corners at the 16-bit extremes clamp to the whole frame, luminance
        set_frame(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 11'd3, 11'd1, FMT_L);
        send_pixel('0, '0, '0, '0);
        send_pixel('1, '0, '1, '0);
        send_pixel(16'h5A5A, '1, '0, '1);
        // both corners in one column: empty rectangle
        set_frame(1, 0, 1, 2, 11'd2, 11'd2, FMT_LA);
        send_random_pixels(4);
        // zero width and height act as one
        set_frame(0, 0, 1, 1, 11'd0, 11'd0, FMT_RGB);
        send_random_pixels(1);
        // corners given in reverse order
        set_frame(3, 2, 1, 0, 11'd4, 11'd3, FMT_RGBA);
        send_random_pixels(12);

        // one-pixel frames while results are held back: the queue fills up
        set_frame(0, 0, 1, 1, 11'd1, 11'd1, FMT_RGBA);
        @(posedge clk);
        hold_wanted = 1'b1;
        calm        = 1'b1;
        send_random_pixels(30);
        calm = 1'b0;

        pixels_sent = 0;
        for (frame_idx = 0; pixels_sent < PIXEL_TARGET; frame_idx++)
        begin
            // a width above the largest frame acts as the largest
            if (frame_idx == 12)
            begin
                w = 11'h7FF;
                h = 11'd1;
            end
            else
            begin
                w = ($urandom_range(15) == 0) ? 11'd0 : 11'($urandom_range(8, 1));
                h = ($urandom_range(15) == 0) ? 11'd0 : 11'($urandom_range(5, 1));
            end
            set_frame(pick_corner(used_dim(w)), pick_corner(used_dim(h)),
                      pick_corner(used_dim(w)), pick_corner(used_dim(h)),
                      w, h, fmt_t'($urandom_range(3)));
            @(posedge clk);
            calm = (frame_idx >= 25 && frame_idx < 35);
            send_random_pixels(frame_pixels);
            pixels_sent += frame_pixels;
        end

        @(negedge clk);
        push <= 1'b0;
        while (expected_left != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("roi_rectangle_color_average_unit_tb: PASS");
        else
            $display("roi_rectangle_color_average_unit_tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
design/roi_avg_pkg.sv
design/roi_avg_queue.sv
design/roi_avg_front.sv
design/roi_avg_accum.sv
design/roi_avg_div.sv
design/roi_rectangle_color_average_unit.sv
design/roi_avg_checker.sv
test/roi_avg_checker.sv
test/roi_rectangle_color_average_unit_tb.sv
